>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// No dependencies; the user supplies clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, off while in reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression that must never be true on a rising edge of clk.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

>>> hw/rtl/tlvd_pkg.sv
// Shared types and constants for the TLV payload deframer.
// No dependencies.
`timescale 1ns / 1ps

package tlvd_pkg;

	localparam int unsigned MAX_PAYLOAD_BYTES = 255;
	localparam int unsigned POS_W             = 9;
	localparam logic [6:0]  GROUP_MASK        = 7'h7F;
	localparam logic [7:0]  MAX_RECORDS_RESET = 8'd16;
	localparam int unsigned FIFO_DEPTH        = 4;
	localparam int unsigned FIFO_PTR_W        = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W        = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned TDATA_W           = 48;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOO_SHORT = 3'd1,
		ST_MALFORMED = 3'd2,
		ST_TOO_MANY  = 3'd3,
		ST_TOO_LONG  = 3'd4
	} status_t;

	typedef enum logic {
		KIND_RECORD = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       item_kind;
		logic [7:0]  record_offset;
		logic [4:0]  record_length;
		logic [7:0]  record_opcode;
		logic [7:0]  record_index;
		logic [6:0]  group_number;
		status_t     status_code;
		logic [7:0]  record_total;
		logic        run_last;
	} res_t;

	// Results produced by one item: r0 first, r1 only when n is two.
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	typedef struct packed {
		logic [FIFO_CNT_W-1:0] count;
		logic                  room2;
	} fifo_stat_t;

endpackage

>>> hw/rtl/tlv_payload_deframer_top.sv
// TLV payload deframer: one payload byte per input item, record and status results out.
// Holds the max_records register; depends on tlvd_pkg, tlvd_parser, tlvd_result_fifo, assert_macros.svh.
// The input register takes one byte per cycle while the result queue has room for two
// results. A byte that completes a record and also ends the payload yields two results,
// which leave the queue one at a time; every other byte yields at most one, so with the
// output ready the block sustains one byte per cycle. A result passes the input register,
// then the four-entry result queue, before it is offered on the output; its byte waits
// in the input register while the queue lacks room for two results.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tlv_payload_deframer_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [7:0]                   cfg_wr_data, // max_records
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,     // [7:0] data_byte
	input  logic                         s_tlast,     // last_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [7:0] record_offset, [12:8] record_length, [20:13] record_opcode,
	// [28:21] record_index, [35:29] group_number, [38:36] status_code,
	// [46:39] record_total, [47] zero
	output logic [tlvd_pkg::TDATA_W-1:0] m_tdata,
	output logic                         m_tuser,     // item_kind
	output logic                         m_tlast      // run_last
);
	import tlvd_pkg::*;

	logic [7:0] max_records_q;
	push_t      push;
	fifo_stat_t fstat;
	res_t       res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_records_q <= MAX_RECORDS_RESET;
		end else if (cfg_wr_en) begin
			max_records_q <= cfg_wr_data;
		end
	end

	tlvd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.max_records (max_records_q),
		.fifo_stat   (fstat),
		.push        (push)
	);

	tlvd_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res),
		.stat      (fstat)
	);

	assign m_tdata = {1'b0, res.record_total, res.status_code, res.group_number,
		res.record_index, res.record_opcode, res.record_length, res.record_offset};
	assign m_tuser = res.item_kind;
	assign m_tlast = res.run_last;

	`ASSERT_NEVER(a_fifo_overflow, fstat.count > FIFO_CNT_W'(FIFO_DEPTH), "result queue overflow")
	`ASSERT_NEVER(a_push_no_room, push.n != 2'd0 && !fstat.room2, "push without room")
	`ASSERT_CLK(a_status_is_last, m_tvalid && m_tuser |-> m_tlast, "status item not last")
	`ASSERT_CLK(a_record_ok, m_tvalid && !m_tuser |-> m_tdata[38:36] == ST_OK, "record with status")

endmodule

>>> hw/rtl/tlvd_parser.sv
// Input register and per-payload parse state; builds up to two results per item.
// Depends on tlvd_pkg.
`timescale 1ns / 1ps

module tlvd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] data_byte
	input  logic                s_tlast,   // last_byte
	input  logic [7:0]          max_records,
	input  tlvd_pkg::fifo_stat_t fifo_stat,
	output tlvd_pkg::push_t     push
);
	import tlvd_pkg::*;

	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             last_s1;

	logic [POS_W-1:0] pos_q, pos_n;
	logic [4:0]       left_q, left_n;
	logic [7:0]       start_q, start_n;
	logic [7:0]       op_q, op_n;
	logic [7:0]       seen_q, seen_n;
	logic [6:0]       group_q, group_n;
	status_t          err_q, err_n;

	logic   fire;
	logic   started;
	logic   desc_v;
	res_t   desc;
	res_t   stat;
	status_t st;

	assign fire     = valid_s1 && fifo_stat.room2;
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_comb begin
		pos_n   = pos_q;
		left_n  = left_q;
		start_n = start_q;
		op_n    = op_q;
		seen_n  = seen_q;
		group_n = group_q;
		err_n   = err_q;
		started = 1'b0;
		desc_v  = 1'b0;
		if (pos_q < POS_W'(MAX_PAYLOAD_BYTES)) begin
			if (pos_q == '0) begin
				group_n = data_s1[6:0] & GROUP_MASK;
			end else if (left_q == '0) begin
				start_n = pos_q[7:0];
				op_n    = data_s1;
				left_n  = {1'b0, data_s1[7:4]} + 5'd1;
				started = 1'b1;
			end else begin
				left_n = left_q - 5'd1;
				if (left_q == 5'd1 && err_q == ST_OK) begin
					if (seen_q >= max_records) begin
						err_n = ST_TOO_MANY;
					end else begin
						desc_v = 1'b1;
						seen_n = seen_q + 8'd1;
					end
				end
			end
			pos_n = pos_q + POS_W'(1);
		end else begin
			pos_n = POS_W'(MAX_PAYLOAD_BYTES + 1);
		end

		if (pos_n < POS_W'(3)) begin
			st = ST_TOO_SHORT;
		end else if (pos_n > POS_W'(MAX_PAYLOAD_BYTES)) begin
			st = ST_TOO_LONG;
		end else if (err_n != ST_OK) begin
			st = err_n;
		end else if (left_n != '0 && !started) begin
			st = ST_MALFORMED;
		end else begin
			st = ST_OK;
		end

		desc.item_kind     = KIND_RECORD;
		desc.record_offset = start_q;
		desc.record_length = {1'b0, op_q[7:4]} + 5'd2;
		desc.record_opcode = op_q;
		desc.record_index  = seen_q;
		desc.group_number  = group_n;
		desc.status_code   = ST_OK;
		desc.record_total  = seen_n;
		desc.run_last      = !last_s1;

		stat.item_kind     = KIND_STATUS;
		stat.record_offset = '0;
		stat.record_length = '0;
		stat.record_opcode = '0;
		stat.record_index  = '0;
		stat.group_number  = group_n;
		stat.status_code   = st;
		stat.record_total  = seen_n;
		stat.run_last      = 1'b1;

		push.n  = 2'd0;
		push.r0 = desc_v ? desc : stat;
		push.r1 = stat;
		if (fire) begin
			push.n = {1'b0, desc_v} + {1'b0, last_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			left_q  <= '0;
			start_q <= '0;
			op_q    <= '0;
			seen_q  <= '0;
			group_q <= '0;
			err_q   <= ST_OK;
		end else if (fire) begin
			if (last_s1) begin
				pos_q   <= '0;
				left_q  <= '0;
				start_q <= '0;
				op_q    <= '0;
				seen_q  <= '0;
				group_q <= '0;
				err_q   <= ST_OK;
			end else begin
				pos_q   <= pos_n;
				left_q  <= left_n;
				start_q <= start_n;
				op_q    <= op_n;
				seen_q  <= seen_n;
				group_q <= group_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

>>> hw/rtl/tlvd_result_fifo.sv
// Four-entry result queue: takes up to two results a cycle, gives one.
// Depends on tlvd_pkg.
`timescale 1ns / 1ps

module tlvd_result_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tlvd_pkg::push_t      push,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tlvd_pkg::res_t       out_res,
	output tlvd_pkg::fifo_stat_t stat
);
	import tlvd_pkg::*;

	res_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] head_q;
	logic [FIFO_PTR_W-1:0] tail_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;

	assign out_valid  = count_q != '0;
	assign out_res    = mem_q[head_q];
	assign pop        = out_valid && out_ready;
	assign stat.count = count_q;
	assign stat.room2 = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[tail_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[tail_q + FIFO_PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + FIFO_PTR_W'(1);
			end
			tail_q  <= tail_q + FIFO_PTR_W'(push.n);
			count_q <= count_q + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
		end
	end

endmodule

>>> bench/tlv_payload_deframer_checker.sv
// Checker for the TLV payload deframer: watches the byte, result and config channels.
// Predicts record and status results per accepted byte and compares them in order.
// Depends on tlvd_pkg.
`timescale 1ns / 1ps

module tlv_payload_deframer_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [7:0]                   cfg_wr_data,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [7:0]                   s_tdata,
	input  logic                         s_tlast,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [tlvd_pkg::TDATA_W-1:0] m_tdata,
	input  logic                         m_tuser,
	input  logic                         m_tlast,
	output int                           mismatches,
	output int                           results_due,
	output int                           records_checked,
	output int                           statuses_checked
);
	import tlvd_pkg::*;

	logic [POS_W-1:0] byte_pos;
	logic [4:0]       owed_bytes;
	logic [7:0]       rec_start;
	logic [7:0]       rec_opcode;
	logic [7:0]       rec_count;
	logic [6:0]       hdr_group;
	status_t          err_latch;
	logic [7:0]       max_records;
	res_t             due_results[$];
	res_t             head;

	initial begin
		mismatches       = 0;
		results_due      = 0;
		records_checked  = 0;
		statuses_checked = 0;
	end

	task automatic clear_payload();
		byte_pos   = '0;
		owed_bytes = '0;
		rec_start  = '0;
		rec_opcode = '0;
		rec_count  = '0;
		hdr_group  = '0;
		err_latch  = ST_OK;
	endtask

	task automatic deframe_byte(input logic [7:0] b, input logic fin);
		res_t             outs[2];
		int               n;
		logic             began;
		logic [POS_W-1:0] idx;
		status_t          st;
		n     = 0;
		began = 1'b0;
		idx   = byte_pos;
		if (idx < MAX_PAYLOAD_BYTES) begin
			if (idx == 0) begin
				hdr_group = b[6:0] & GROUP_MASK;
			end else if (owed_bytes == 0) begin
				rec_start  = idx[7:0];
				rec_opcode = b;
				owed_bytes = {1'b0, b[7:4]} + 5'd1;
				began      = 1'b1;
			end else begin
				owed_bytes = owed_bytes - 5'd1;
				if (owed_bytes == 0 && err_latch == ST_OK) begin
					if (rec_count >= max_records) begin
						err_latch = ST_TOO_MANY;
					end else begin
						outs[n]               = '0;
						outs[n].item_kind     = KIND_RECORD;
						outs[n].record_offset = rec_start;
						outs[n].record_length = {1'b0, rec_opcode[7:4]} + 5'd2;
						outs[n].record_opcode = rec_opcode;
						outs[n].record_index  = rec_count;
						rec_count             = rec_count + 8'd1;
						outs[n].group_number  = hdr_group;
						outs[n].status_code   = ST_OK;
						outs[n].record_total  = rec_count;
						n++;
					end
				end
			end
			byte_pos = idx + 1'b1;
		end else begin
			byte_pos = POS_W'(MAX_PAYLOAD_BYTES + 1);
		end

		if (fin) begin
			if (byte_pos < 3)
				st = ST_TOO_SHORT;
			else if (byte_pos > MAX_PAYLOAD_BYTES)
				st = ST_TOO_LONG;
			else if (err_latch != ST_OK)
				st = err_latch;
			else if (owed_bytes != 0 && !began)
				st = ST_MALFORMED;
			else
				st = ST_OK;
			outs[n]              = '0;
			outs[n].item_kind    = KIND_STATUS;
			outs[n].group_number = hdr_group;
			outs[n].status_code  = st;
			outs[n].record_total = rec_count;
			n++;
			clear_payload();
		end

		if (n > 0)
			outs[n-1].run_last = 1'b1;
		for (int i = 0; i < n; i++)
			due_results.push_back(outs[i]);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_payload();
			max_records = MAX_RECORDS_RESET;
			due_results.delete();
		end else begin
			if (s_tvalid && s_tready)
				deframe_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$error("result with nothing expected: tuser=%0d tdata=%h", m_tuser, m_tdata);
					mismatches++;
				end else begin
					head = due_results.pop_front();
					check_field("item_kind", head.item_kind, m_tuser);
					check_field("record_offset", head.record_offset, m_tdata[7:0]);
					check_field("record_length", head.record_length, m_tdata[12:8]);
					check_field("record_opcode", head.record_opcode, m_tdata[20:13]);
					check_field("record_index", head.record_index, m_tdata[28:21]);
					check_field("group_number", head.group_number, m_tdata[35:29]);
					check_field("status_code", head.status_code, m_tdata[38:36]);
					check_field("record_total", head.record_total, m_tdata[46:39]);
					check_field("tdata pad bit", 0, m_tdata[47]);
					check_field("run_last", head.run_last, m_tlast);
					if (head.item_kind == KIND_STATUS)
						statuses_checked++;
					else
						records_checked++;
				end
			end
			if (cfg_wr_en)
				max_records = cfg_wr_data;
		end
		results_due = due_results.size();
	end

endmodule

>>> bench/tlv_payload_deframer_top_tb.sv
// Testbench top for the TLV payload deframer: clock, reset, byte stimulus, output stalls.
// Verdict comes from tlv_payload_deframer_checker; depends on tlvd_pkg and the RTL.
`timescale 1ns / 1ps

module tlv_payload_deframer_top_tb;
	import tlvd_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = 8;
	localparam int PHASE_BYTES  = 80;

	typedef logic [7:0] byte_q_t[$];

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_wr_en   = 1'b0;
	logic [7:0]         cfg_wr_data = 8'd0;
	logic               s_tvalid    = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata     = 8'd0;
	logic               s_tlast     = 1'b0;
	logic               m_tvalid;
	logic               m_tready    = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tuser;
	logic               m_tlast;

	int mismatches;
	int results_due;
	int records_checked;
	int statuses_checked;

	int cycles        = 0;
	int bytes_sent    = 0;
	int payloads_sent = 0;
	int cfg_writes    = 0;
	int hold_requests = 0;
	int holds_done    = 0;
	int stall_left    = 0;
	bit send_idle     = 1'b0;
	bit recv_idle     = 1'b0;

	tlv_payload_deframer_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

	tlv_payload_deframer_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tlast          (s_tlast),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tuser          (m_tuser),
		.m_tlast          (m_tlast),
		.mismatches       (mismatches),
		.results_due      (results_due),
		.records_checked  (records_checked),
		.statuses_checked (statuses_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned gap_len();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// output side: random stalls plus the long hold-off on request
	always @(posedge clk) begin
		if (holds_done != hold_requests) begin
			holds_done = holds_done + 1;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else if (recv_idle && $urandom_range(0, 99) < 25) begin
			stall_left = gap_len() - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_byte(input logic [7:0] d, input logic fin);
		int unsigned gap;
		gap = (send_idle && $urandom_range(0, 99) < 25) ? gap_len() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic send_payload(input byte_q_t p);
		foreach (p[i])
			send_byte(p[i], i == p.size() - 1);
		payloads_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_max_records(input logic [7:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		cfg_writes++;
	endtask

	function automatic void add_record(ref byte_q_t p, input int unsigned nib);
		p.push_back({nib[3:0], 4'($urandom)});
		repeat (nib + 1) p.push_back(8'($urandom));
	endfunction

	// header, then well-formed records, sometimes ending in a cut-off record
	// or a lone opcode; a tenth of the payloads are plain noise
	function automatic byte_q_t make_payload();
		byte_q_t     p;
		int unsigned sel;
		int unsigned nib;
		p.push_back(8'($urandom));
		sel = $urandom_range(0, 99);
		if (sel < 10) begin
			repeat ($urandom_range(0, 19)) p.push_back(8'($urandom));
			return p;
		end
		repeat ($urandom_range(0, 6)) begin
			nib = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
			add_record(p, nib);
		end
		if (sel < 25) begin
			nib = $urandom_range(1, 15);
			p.push_back({nib[3:0], 4'($urandom)});
			repeat ($urandom_range(1, nib)) p.push_back(8'($urandom));
		end else if (sel < 45) begin
			p.push_back(8'($urandom));
		end
		return p;
	endfunction

	function automatic byte_q_t make_long(input int unsigned len);
		byte_q_t p;
		p.push_back(8'($urandom));
		while (p.size() < len)
			add_record(p, $urandom_range(0, 15));
		while (p.size() > len)
			void'(p.pop_back());
		return p;
	endfunction

	initial begin
		byte_q_t    p;
		logic [7:0] cfg_plan[6];
		int         phase_bytes;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset value of max_records
		send_payload('{8'hFF});                             // too short, one byte
		send_payload('{8'h80, 8'h00});                      // too short, lone opcode
		send_payload('{8'h7F, 8'h00, 8'hAA});               // record and status together
		send_payload('{8'h01, 8'h10, 8'h55, 8'hAA, 8'h05}); // lone trailing opcode
		send_payload('{8'h02, 8'h2F, 8'hFF, 8'h00});        // cut-off record
		drain();

		write_max_records(8'd0);
		send_payload('{8'h04, 8'h00, 8'h11, 8'h30});        // limit hit on first record
		send_payload('{8'h85, 8'h00, 8'hEE, 8'h20, 8'h01}); // too_many over malformed
		drain();

		cfg_plan = '{8'd255, 8'd1, 8'd3, 8'($urandom), 8'd0, MAX_RECORDS_RESET};
		for (int ph = 0; ph < 6; ph++) begin
			write_max_records(cfg_plan[ph]);
			send_idle = (ph >= 2);
			recv_idle = (ph >= 1);
			if (ph == 1)
				hold_requests++;
			if (ph == 0) begin
				send_payload(make_long(MAX_PAYLOAD_BYTES));
				send_payload(make_long(MAX_PAYLOAD_BYTES + 2));
			end
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				p = make_payload();
				send_payload(p);
				phase_bytes += p.size();
			end
			drain();
		end

		$display("sent %0d payloads, %0d bytes, under %0d max_records settings",
			payloads_sent, bytes_sent, cfg_writes);
		$display("compared %0d record results and %0d status results",
			records_checked, statuses_checked);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> tlv_payload_deframer_top.f
+incdir+hw/rtl
hw/rtl/tlvd_pkg.sv
hw/rtl/tlvd_parser.sv
hw/rtl/tlvd_result_fifo.sv
hw/rtl/tlv_payload_deframer_top.sv
bench/tlv_payload_deframer_checker.sv
bench/tlv_payload_deframer_top_tb.sv
